### rtl/gms_pkg.sv
// ----------------------------------------------------------------------------
// Grouped mode selector package
// Shared item types, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package gms_pkg;

    localparam logic [7:0] OFF_CODE = 8'hFF;

    localparam logic [3:0] FUNC_OFF        = 4'd0;
    localparam logic [3:0] FUNC_PREF       = 4'd1;
    localparam logic [3:0] FUNC_TEMP       = 4'd2;
    localparam logic [3:0] FUNC_NUMBER     = 4'd3;
    localparam logic [3:0] FUNC_NEXT       = 4'd4;
    localparam logic [3:0] FUNC_NEXT_GROUP = 4'd5;
    localparam logic [3:0] FUNC_PREV       = 4'd6;
    localparam logic [3:0] FUNC_PREV_GROUP = 4'd7;

    localparam logic [2:0] REG_SKIP  = 3'd0;
    localparam logic [2:0] REG_FIRST = 3'd1;
    localparam logic [2:0] REG_LAST  = 3'd2;
    localparam logic [2:0] REG_PREF  = 3'd3;
    localparam logic [2:0] REG_TEMP  = 3'd4;

    localparam logic [7:0] SKIP_RESET  = 8'd240;
    localparam logic [7:0] FIRST_RESET = 8'd21;
    localparam logic [7:0] LAST_RESET  = 8'd138;

    typedef struct packed {
        logic [3:0] func;
        logic [7:0] mode_number;
    } gms_in_t;

    typedef struct packed {
        logic [7:0] new_mode;
        logic       relay_request;
    } gms_out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_STEP_ADV,
        ST_STEP_WALK,
        ST_STEP_CHK,
        ST_STEP_CIRC,
        ST_GRP_ALIGN,
        ST_GRP_HOP,
        ST_GRP_VFIRST,
        ST_GRP_VSCAN,
        ST_GRP_POS,
        ST_COMMIT
    } ctrl_state_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_RES_SIMPLE,
        OP_RES_BOUND,
        OP_RES_N,
        OP_RES_OFF,
        OP_MV,
        OP_BACK,
        OP_INC_K,
        OP_CLR_K,
        OP_MV_INC_K,
        OP_BACK_POS,
        OP_GRP_OOR,
        OP_MV_V,
        OP_V_DEC,
        OP_V_INC,
        OP_MV_POS,
        OP_STEP_INIT,
        OP_COMMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic is_step;
        logic is_group;
        logic cur_oor;
        logic bound_off;
        logic edge_fwd;
        logic edge_back;
        logic n_skip;
        logic n_eq_cur;
        logic k_last;
        logic k_full;
        logic v_first;
        logic v_last;
        logic v_skip;
        logic pos_zero;
        logic rsp_free;
    } dp_status_t;

endpackage

### rtl/gms_datapath.sv
// ----------------------------------------------------------------------------
// Grouped mode selector datapath
// Holds the mask registers, the mode state, the walk cursors and the result
// register, and carries out one controller command per cycle.
// ----------------------------------------------------------------------------
module gms_datapath
    import gms_pkg::*;
#(
    parameter int MODE_COUNT = 8
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  gms_in_t    req,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_data,
    input  dp_cmd_t    cmd,
    output dp_status_t status,
    output logic       rsp_valid,
    input  logic       rsp_ready,
    output gms_out_t   rsp
);

    localparam int IW    = $clog2(MODE_COUNT);
    localparam int KW    = $clog2(MODE_COUNT + 1);
    localparam int LOW_N = (MODE_COUNT < 8) ? MODE_COUNT : 8;
    localparam logic [IW-1:0] LAST_IDX     = IW'(MODE_COUNT - 1);
    localparam logic [KW-1:0] K_FULL       = KW'(MODE_COUNT);
    localparam logic [KW-1:0] K_LAST       = KW'(MODE_COUNT - 1);
    localparam logic [7:0]    MODE_COUNT_B = 8'(MODE_COUNT);

    logic [7:0]    skip_mask_reg;
    logic [7:0]    first_mask_reg;
    logic [7:0]    last_mask_reg;
    logic [7:0]    pref_mask_reg;
    logic [7:0]    temp_mask_reg;
    logic [7:0]    active_reg;
    logic [7:0]    remembered_reg;
    logic          rsp_valid_reg;
    gms_out_t      rsp_reg;

    logic [3:0]    func_reg;
    logic [7:0]    num_reg;
    logic          fwd_reg;
    logic [IW-1:0] n_reg;
    logic [IW-1:0] v_reg;
    logic [IW-1:0] cur_reg;
    logic [IW-1:0] pos_reg;
    logic [KW-1:0] k_reg;
    logic [7:0]    res_reg;

    logic [MODE_COUNT-1:0] skip_vec;
    logic [MODE_COUNT-1:0] first_vec;
    logic [MODE_COUNT-1:0] last_vec;

    logic [IW-1:0] mv_n;
    logic [IW-1:0] back_n;
    logic          low_found;
    logic [IW-1:0] low_idx;
    logic          high_found;
    logic [IW-1:0] high_idx;
    logic [7:0]    low_b;
    logic [7:0]    high_b;
    logic [7:0]    bound_b;
    logic [7:0]    pref_mk;
    logic [7:0]    temp_mk;
    logic [7:0]    simple_res;
    logic          remember;
    logic          relay;

    function automatic logic [7:0] marker(input logic [7:0] m);
        logic [7:0] r;
        r = OFF_CODE;
        for (int i = LOW_N - 1; i >= 0; i--) begin
            if (m[i]) begin
                r = 8'(i);
            end
        end
        return r;
    endfunction

    for (genvar gi = 0; gi < MODE_COUNT; gi++) begin : g_mode
        if (gi < 8) begin : g_low
            assign skip_vec[gi]  = skip_mask_reg[gi];
            assign first_vec[gi] = (gi == 0) || first_mask_reg[gi];
            assign last_vec[gi]  = (gi == MODE_COUNT - 1) || last_mask_reg[gi];
        end else begin : g_high
            assign skip_vec[gi]  = 1'b0;
            assign first_vec[gi] = 1'b0;
            assign last_vec[gi]  = (gi == MODE_COUNT - 1);
        end
    end

    always_comb
    begin
        if (fwd_reg)
        begin
            mv_n   = (n_reg == LAST_IDX) ? '0 : n_reg + IW'(1);
            back_n = (n_reg == '0) ? LAST_IDX : n_reg - IW'(1);
        end
        else
        begin
            mv_n   = (n_reg == '0) ? LAST_IDX : n_reg - IW'(1);
            back_n = (n_reg == LAST_IDX) ? '0 : n_reg + IW'(1);
        end
    end

    always_comb
    begin
        low_found  = 1'b0;
        low_idx    = '0;
        high_found = 1'b0;
        high_idx   = '0;
        for (int i = LOW_N - 1; i >= 0; i--) begin
            if (!skip_mask_reg[i]) begin
                low_found = 1'b1;
                low_idx   = IW'(i);
            end
        end
        for (int i = 0; i < LOW_N; i++) begin
            if (!skip_mask_reg[i]) begin
                high_found = 1'b1;
                high_idx   = IW'(i);
            end
        end
    end

    assign low_b   = low_found ? 8'(low_idx) : ((MODE_COUNT > 8) ? 8'd8 : OFF_CODE);
    assign high_b  = (MODE_COUNT > 8) ? 8'(LAST_IDX) :
                     (high_found ? 8'(high_idx) : OFF_CODE);
    assign bound_b = fwd_reg ? low_b : high_b;
    assign pref_mk = marker(pref_mask_reg);
    assign temp_mk = marker(temp_mask_reg);

    always_comb
    begin
        unique case (func_reg)
            FUNC_OFF:    simple_res = OFF_CODE;
            FUNC_PREF:   simple_res = (active_reg == pref_mk) ? OFF_CODE : pref_mk;
            FUNC_TEMP:   simple_res = (active_reg == temp_mk) ? remembered_reg : temp_mk;
            FUNC_NUMBER: simple_res = (num_reg >= MODE_COUNT_B) ? OFF_CODE : num_reg;
            default:     simple_res = active_reg;
        endcase
    end

    assign relay    = (func_reg != FUNC_TEMP);
    assign remember = (func_reg <= FUNC_PREV_GROUP) && (func_reg != FUNC_TEMP);

    assign status.is_step   = (func_reg == FUNC_NEXT) || (func_reg == FUNC_PREV);
    assign status.is_group  = (func_reg == FUNC_NEXT_GROUP) || (func_reg == FUNC_PREV_GROUP);
    assign status.cur_oor   = (active_reg >= MODE_COUNT_B);
    assign status.bound_off = (bound_b == OFF_CODE);
    assign status.edge_fwd  = fwd_reg ? last_vec[n_reg] : first_vec[n_reg];
    assign status.edge_back = fwd_reg ? first_vec[n_reg] : last_vec[n_reg];
    assign status.n_skip    = skip_vec[n_reg];
    assign status.n_eq_cur  = (n_reg == cur_reg);
    assign status.k_last    = (k_reg == K_LAST);
    assign status.k_full    = (k_reg == K_FULL);
    assign status.v_first   = first_vec[v_reg];
    assign status.v_last    = last_vec[v_reg];
    assign status.v_skip    = skip_vec[v_reg];
    assign status.pos_zero  = (pos_reg == '0);
    assign status.rsp_free  = !rsp_valid_reg || rsp_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skip_mask_reg  <= SKIP_RESET;
            first_mask_reg <= FIRST_RESET;
            last_mask_reg  <= LAST_RESET;
            pref_mask_reg  <= 8'd0;
            temp_mask_reg  <= 8'd0;
            active_reg     <= OFF_CODE;
            remembered_reg <= OFF_CODE;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_SKIP:  skip_mask_reg  <= cfg_data;
                    REG_FIRST: first_mask_reg <= cfg_data;
                    REG_LAST:  last_mask_reg  <= cfg_data;
                    REG_PREF:  pref_mask_reg  <= cfg_data;
                    REG_TEMP:  temp_mask_reg  <= cfg_data;
                    default:   ;
                endcase
            end
            if (cmd.op == OP_COMMIT)
            begin
                active_reg    <= res_reg;
                rsp_valid_reg <= 1'b1;
                if (remember)
                begin
                    remembered_reg <= res_reg;
                end
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_LOAD:
            begin
                func_reg <= req.func;
                num_reg  <= req.mode_number;
                fwd_reg  <= !((req.func == FUNC_PREV) || (req.func == FUNC_PREV_GROUP));
                n_reg    <= active_reg[IW-1:0];
                cur_reg  <= active_reg[IW-1:0];
                k_reg    <= '0;
                pos_reg  <= '0;
            end
            OP_RES_SIMPLE: res_reg <= simple_res;
            OP_RES_BOUND:  res_reg <= bound_b;
            OP_RES_N:      res_reg <= 8'(n_reg);
            OP_RES_OFF:    res_reg <= OFF_CODE;
            OP_MV:         n_reg <= mv_n;
            OP_BACK:       n_reg <= back_n;
            OP_INC_K:      k_reg <= k_reg + KW'(1);
            OP_CLR_K:      k_reg <= '0;
            OP_MV_INC_K:
            begin
                n_reg <= mv_n;
                k_reg <= k_reg + KW'(1);
            end
            OP_BACK_POS:
            begin
                n_reg   <= back_n;
                pos_reg <= pos_reg + IW'(1);
            end
            OP_GRP_OOR:
            begin
                n_reg   <= bound_b[IW-1:0];
                pos_reg <= fwd_reg ? bound_b[IW-1:0] : '0;
                k_reg   <= '0;
            end
            OP_MV_V:
            begin
                n_reg <= mv_n;
                v_reg <= mv_n;
            end
            OP_V_DEC:      v_reg <= v_reg - IW'(1);
            OP_V_INC:      v_reg <= v_reg + IW'(1);
            OP_MV_POS:
            begin
                n_reg   <= mv_n;
                pos_reg <= pos_reg - IW'(1);
            end
            OP_STEP_INIT:
            begin
                cur_reg <= n_reg;
                k_reg   <= '0;
            end
            OP_COMMIT:
            begin
                rsp_reg.new_mode      <= res_reg;
                rsp_reg.relay_request <= relay;
            end
            default: ;
        endcase
    end

    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

### rtl/gms_ctrl.sv
// ----------------------------------------------------------------------------
// Grouped mode selector controller
// Sequences the mode walks and issues one datapath command per cycle.
// ----------------------------------------------------------------------------
module gms_ctrl
    import gms_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (status.is_step)
                begin
                    state_next = status.cur_oor ? ST_COMMIT : ST_STEP_ADV;
                end
                else if (status.is_group)
                begin
                    if (!status.cur_oor)
                    begin
                        state_next = ST_GRP_ALIGN;
                    end
                    else
                    begin
                        state_next = status.bound_off ? ST_COMMIT : ST_GRP_HOP;
                    end
                end
                else
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_STEP_ADV:
            begin
                state_next = status.edge_fwd ? ST_STEP_WALK : ST_STEP_CHK;
            end
            ST_STEP_WALK:
            begin
                if (status.edge_back)
                begin
                    state_next = ST_STEP_CHK;
                end
            end
            ST_STEP_CHK:
            begin
                if (!status.n_skip)
                begin
                    state_next = ST_COMMIT;
                end
                else if (status.n_eq_cur || status.k_last)
                begin
                    state_next = ST_STEP_CIRC;
                end
                else
                begin
                    state_next = ST_STEP_ADV;
                end
            end
            ST_STEP_CIRC:
            begin
                if (status.k_full || !status.n_skip)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_GRP_ALIGN:
            begin
                if (status.edge_back)
                begin
                    state_next = ST_GRP_HOP;
                end
            end
            ST_GRP_HOP:
            begin
                if (status.edge_fwd)
                begin
                    state_next = ST_GRP_VFIRST;
                end
            end
            ST_GRP_VFIRST:
            begin
                if (status.v_first)
                begin
                    state_next = ST_GRP_VSCAN;
                end
            end
            ST_GRP_VSCAN:
            begin
                if (!status.v_skip)
                begin
                    state_next = ST_GRP_POS;
                end
                else if (status.v_last)
                begin
                    state_next = status.k_full ? ST_COMMIT : ST_GRP_HOP;
                end
            end
            ST_GRP_POS:
            begin
                if (status.pos_zero || status.edge_fwd)
                begin
                    state_next = status.n_skip ? ST_STEP_ADV : ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                if (status.rsp_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.op    = OP_NONE;
        req_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.op = OP_LOAD;
                end
            end
            ST_DECODE:
            begin
                if (status.is_step)
                begin
                    if (status.cur_oor)
                    begin
                        cmd.op = OP_RES_BOUND;
                    end
                end
                else if (status.is_group)
                begin
                    if (status.cur_oor)
                    begin
                        cmd.op = status.bound_off ? OP_RES_BOUND : OP_GRP_OOR;
                    end
                end
                else
                begin
                    cmd.op = OP_RES_SIMPLE;
                end
            end
            ST_STEP_ADV:
            begin
                if (!status.edge_fwd)
                begin
                    cmd.op = OP_MV;
                end
            end
            ST_STEP_WALK:
            begin
                if (!status.edge_back)
                begin
                    cmd.op = OP_BACK;
                end
            end
            ST_STEP_CHK:
            begin
                if (!status.n_skip)
                begin
                    cmd.op = OP_RES_N;
                end
                else if (status.n_eq_cur || status.k_last)
                begin
                    cmd.op = OP_CLR_K;
                end
                else
                begin
                    cmd.op = OP_INC_K;
                end
            end
            ST_STEP_CIRC:
            begin
                if (status.k_full)
                begin
                    cmd.op = OP_RES_OFF;
                end
                else if (!status.n_skip)
                begin
                    cmd.op = OP_RES_N;
                end
                else
                begin
                    cmd.op = OP_MV_INC_K;
                end
            end
            ST_GRP_ALIGN:
            begin
                if (!status.edge_back)
                begin
                    cmd.op = OP_BACK_POS;
                end
            end
            ST_GRP_HOP:
            begin
                cmd.op = status.edge_fwd ? OP_MV_V : OP_MV;
            end
            ST_GRP_VFIRST:
            begin
                if (!status.v_first)
                begin
                    cmd.op = OP_V_DEC;
                end
            end
            ST_GRP_VSCAN:
            begin
                if (status.v_skip)
                begin
                    if (status.v_last)
                    begin
                        cmd.op = status.k_full ? OP_RES_BOUND : OP_INC_K;
                    end
                    else
                    begin
                        cmd.op = OP_V_INC;
                    end
                end
            end
            ST_GRP_POS:
            begin
                if (status.pos_zero || status.edge_fwd)
                begin
                    cmd.op = status.n_skip ? OP_STEP_INIT : OP_RES_N;
                end
                else
                begin
                    cmd.op = OP_MV_POS;
                end
            end
            ST_COMMIT:
            begin
                if (status.rsp_free)
                begin
                    cmd.op = OP_COMMIT;
                end
            end
            default: cmd.op = OP_NONE;
        endcase
    end

endmodule

### rtl/grouped_mode_selector_unit.sv
// ----------------------------------------------------------------------------
// Grouped mode selector unit
// Tracks the active and remembered operating mode and applies button events.
// ----------------------------------------------------------------------------
// An event item enters on the req channel (valid/ready) and produces exactly
// one result item on the rsp channel: the new mode (255 means off) and the
// relay flag. The cfg channel writes the skip, first, last, preferred and
// temporary mode masks by index; it is always ready.
// Off, preferred, temporary, set-by-number and unused events go from
// acceptance through a decode state and a commit state to a valid result.
// Stepping and group jumps walk the mode table in the controller loop, so
// their latency grows with the group layout.
// One event is in work at a time; the next event is accepted as soon as the
// previous result sits in the output register, even if it is not yet taken.
// If the receiver stalls, the held result blocks only the next commit.
// Reset restores the mask defaults and sets both modes to off.
// ----------------------------------------------------------------------------
module grouped_mode_selector_unit
    import gms_pkg::*;
#(
    parameter int MODE_COUNT = 8
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    input  gms_in_t    req,
    output logic       rsp_valid,
    input  logic       rsp_ready,
    output gms_out_t   rsp,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    gms_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .status    (status),
        .cmd       (cmd)
    );

    gms_datapath #(
        .MODE_COUNT (MODE_COUNT)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule
